/* sv/cht_pkg.sv */
// Shared types and constants of the chained hash table.
// Holds the table geometry, the operation and status codes, and the
// command and status structs between the controller and the datapath.
package cht_pkg;

	// Table geometry.
	localparam int NUM_BUCKETS      = 7;
	localparam int SLOTS_PER_BUCKET = 16;

	// Fixed field widths of the request and response channels.
	localparam int OPC_W    = 2;
	localparam int KEY_W    = 32;
	localparam int FRAC_W   = 8;
	localparam int INT_W    = KEY_W - FRAC_W;
	localparam int STATUS_W = 2;
	localparam int BIDX_W   = 3;
	localparam int POS_W    = 4;

	// Derived widths.
	localparam int BKT_W  = $clog2(NUM_BUCKETS);
	localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int CNT_W  = $clog2(SLOTS_PER_BUCKET + 1);
	localparam int ADDR_W = $clog2(NUM_BUCKETS * SLOTS_PER_BUCKET);
	localparam int DEPTH  = NUM_BUCKETS * SLOTS_PER_BUCKET;
	localparam int TOT_W  = $clog2(NUM_BUCKETS * SLOTS_PER_BUCKET + 1);

	// Constant division of the integer key part by the bucket count:
	// q = (x * HASH_M) >> HASH_S is exact for every 24-bit x.
	localparam int HASH_L  = $clog2(NUM_BUCKETS);
	localparam int HASH_S  = INT_W + HASH_L;
	localparam int HASH_MW = INT_W + 1;
	localparam longint unsigned HASH_M =
		((64'd1 << HASH_S) + NUM_BUCKETS - 1) / NUM_BUCKETS;
	localparam int PROD_W  = INT_W + HASH_MW;
	localparam int QUO_W   = PROD_W - HASH_S;

	typedef enum logic [OPC_W-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH_MUL,
		S_HASH_MOD,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic hash_mul;
		logic hash_mod;
		logic insert;
		logic clear;
		logic scan_start;
		logic scan_step;
		logic shift_step;
		logic finish;
	} cht_cmd_t;

	typedef struct packed {
		op_t  op;
		logic scan_hit;
		logic scan_miss;
		logic shift_done;
		logic out_free;
	} cht_sts_t;

endpackage

/* sv/cht_req_if.sv */
// Request channel of the chained hash table: operation code and key.
// Depends on cht_pkg for the field widths.
interface cht_req_if;
	logic                       valid;
	logic                       ready;
	logic [cht_pkg::OPC_W-1:0]  opcode;
	logic [cht_pkg::KEY_W-1:0]  key;

	modport source (output valid, opcode, key, input ready);
	modport sink (input valid, opcode, key, output ready);
endinterface

/* sv/cht_rsp_if.sv */
// Response channel of the chained hash table: status, bucket, slot, empty flag.
// Depends on cht_pkg for the field widths.
interface cht_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cht_pkg::STATUS_W-1:0]  status;
	logic [cht_pkg::BIDX_W-1:0]    bucket_index;
	logic [cht_pkg::POS_W-1:0]     position;
	logic                          table_empty;

	modport source (output valid, status, bucket_index, position, table_empty, input ready);
	modport sink (input valid, status, bucket_index, position, table_empty, output ready);
endinterface

/* sv/cht_dp.sv */
// Datapath of the chained hash table: key store memory, fill counters,
// hash unit, scan and shift sequencing, and the response register.
// Depends on cht_pkg.
module cht_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cht_pkg::cht_cmd_t             cmd,
	output cht_pkg::cht_sts_t             sts,
	input  logic [cht_pkg::OPC_W-1:0]     in_opcode,
	input  logic [cht_pkg::KEY_W-1:0]     in_key,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [cht_pkg::STATUS_W-1:0]  out_status,
	output logic [cht_pkg::BIDX_W-1:0]    out_bucket_index,
	output logic [cht_pkg::POS_W-1:0]     out_position,
	output logic                          out_table_empty
);

	// Request registers.
	cht_pkg::op_t                   op_q;
	logic [cht_pkg::KEY_W-1:0]      key_q;
	logic [cht_pkg::PROD_W-1:0]     prod_s1;
	logic [cht_pkg::BKT_W-1:0]      bkt_q;

	// Table state.
	logic [cht_pkg::KEY_W-1:0]      mem [cht_pkg::DEPTH];
	logic [cht_pkg::KEY_W-1:0]      rdata_q;
	logic [cht_pkg::CNT_W-1:0]      fill_q [cht_pkg::NUM_BUCKETS];
	logic [cht_pkg::TOT_W-1:0]      total_q;

	// Scan and shift sequencing.
	logic [cht_pkg::CNT_W-1:0]      idx_q;
	logic [cht_pkg::SLOT_W-1:0]     cmp_idx_q;
	logic                           cmp_vld_q;
	logic [cht_pkg::CNT_W-1:0]      sh_rd_q;
	logic [cht_pkg::SLOT_W-1:0]     wr_idx_q;
	logic                           wr_vld_q;

	// Result registers.
	cht_pkg::status_t               res_status_q;
	logic [cht_pkg::SLOT_W-1:0]     pos_q;
	cht_pkg::status_t               out_status_q;
	logic [cht_pkg::BIDX_W-1:0]     out_bkt_q;
	logic [cht_pkg::POS_W-1:0]      out_pos_q;
	logic                           out_empty_q;
	logic                           out_valid_q;

	logic [cht_pkg::INT_W-1:0]      key_int;
	logic [cht_pkg::QUO_W-1:0]      quo;
	logic [cht_pkg::INT_W-1:0]      rem;
	logic [cht_pkg::CNT_W-1:0]      cur_fill;
	logic                           bkt_full;
	logic                           scan_issue;
	logic                           scan_hit;
	logic                           scan_miss;
	logic                           sh_issue;
	logic                           shift_done;
	logic [cht_pkg::CNT_W-1:0]      sh_prev;
	logic [cht_pkg::ADDR_W-1:0]     raddr;
	logic [cht_pkg::ADDR_W-1:0]     waddr;
	logic [cht_pkg::KEY_W-1:0]      wdata;
	logic                           mem_we;

	function automatic logic [cht_pkg::ADDR_W-1:0] addr_of(
		input logic [cht_pkg::BKT_W-1:0]  bkt,
		input logic [cht_pkg::SLOT_W-1:0] slot
	);
		return cht_pkg::ADDR_W'(bkt) * cht_pkg::ADDR_W'(cht_pkg::SLOTS_PER_BUCKET)
			+ cht_pkg::ADDR_W'(slot);
	endfunction

	assign key_int  = key_q[cht_pkg::KEY_W-1:cht_pkg::FRAC_W];
	assign quo      = prod_s1[cht_pkg::PROD_W-1:cht_pkg::HASH_S];
	assign rem      = key_int - cht_pkg::INT_W'(quo * cht_pkg::NUM_BUCKETS);
	assign cur_fill = fill_q[bkt_q];
	assign bkt_full = (cur_fill == cht_pkg::CNT_W'(cht_pkg::SLOTS_PER_BUCKET));

	// Scan: one slot read issued per cycle, compared on the next cycle.
	assign scan_issue = (idx_q < cur_fill);
	assign scan_hit   = cmp_vld_q && (rdata_q == key_q);
	assign scan_miss  = !cmp_vld_q && !scan_issue;

	// Shift: read slot i+1 and write it into slot i in the next cycle.
	assign sh_issue   = (sh_rd_q < cur_fill);
	assign shift_done = !wr_vld_q && !sh_issue;
	assign sh_prev    = sh_rd_q - 1'b1;

	assign raddr = cmd.shift_step ? addr_of(bkt_q, sh_rd_q[cht_pkg::SLOT_W-1:0])
		: addr_of(bkt_q, idx_q[cht_pkg::SLOT_W-1:0]);

	always_comb begin
		mem_we = 1'b0;
		waddr  = addr_of(bkt_q, wr_idx_q);
		wdata  = rdata_q;
		if (cmd.insert && !bkt_full) begin
			mem_we = 1'b1;
			waddr  = addr_of(bkt_q, cur_fill[cht_pkg::SLOT_W-1:0]);
			wdata  = key_q;
		end else if (cmd.shift_step && wr_vld_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Request capture and hash.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= cht_pkg::op_t'(in_opcode);
			key_q <= in_key;
		end
		if (cmd.hash_mul) begin
			prod_s1 <= cht_pkg::PROD_W'(key_int) * cht_pkg::PROD_W'(cht_pkg::HASH_M);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < cht_pkg::NUM_BUCKETS; b++) begin
				fill_q[b] <= '0;
			end
			total_q      <= '0;
			bkt_q        <= '0;
			idx_q        <= '0;
			cmp_idx_q    <= '0;
			cmp_vld_q    <= 1'b0;
			sh_rd_q      <= '0;
			wr_idx_q     <= '0;
			wr_vld_q     <= 1'b0;
			res_status_q <= cht_pkg::ST_OK;
			pos_q        <= '0;
		end else begin
			if (cmd.load) begin
				res_status_q <= cht_pkg::ST_OK;
				pos_q        <= '0;
			end
			if (cmd.hash_mod) begin
				bkt_q <= cht_pkg::BKT_W'(rem);
			end
			if (cmd.insert) begin
				if (bkt_full) begin
					res_status_q <= cht_pkg::ST_FULL;
				end else begin
					fill_q[bkt_q] <= cur_fill + 1'b1;
					total_q       <= total_q + 1'b1;
					pos_q         <= cur_fill[cht_pkg::SLOT_W-1:0];
				end
			end
			if (cmd.clear) begin
				for (int b = 0; b < cht_pkg::NUM_BUCKETS; b++) begin
					fill_q[b] <= '0;
				end
				total_q <= '0;
				bkt_q   <= '0;
			end
			if (cmd.scan_start) begin
				idx_q     <= '0;
				cmp_vld_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				cmp_vld_q <= scan_issue;
				if (scan_issue) begin
					idx_q     <= idx_q + 1'b1;
					cmp_idx_q <= idx_q[cht_pkg::SLOT_W-1:0];
				end
				if (scan_hit) begin
					pos_q    <= cmp_idx_q;
					sh_rd_q  <= cht_pkg::CNT_W'(cmp_idx_q) + 1'b1;
					wr_vld_q <= 1'b0;
				end else if (scan_miss) begin
					res_status_q <= cht_pkg::ST_NOT_FOUND;
				end
			end
			if (cmd.shift_step) begin
				wr_vld_q <= sh_issue;
				if (sh_issue) begin
					sh_rd_q  <= sh_rd_q + 1'b1;
					wr_idx_q <= sh_prev[cht_pkg::SLOT_W-1:0];
				end
				if (shift_done) begin
					fill_q[bkt_q] <= cur_fill - 1'b1;
					total_q       <= total_q - 1'b1;
				end
			end
		end
	end

	// Response register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status_q <= res_status_q;
			out_bkt_q    <= cht_pkg::BIDX_W'(bkt_q);
			out_pos_q    <= cht_pkg::POS_W'(pos_q);
			out_empty_q  <= (total_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_status       = out_status_q;
	assign out_bucket_index = out_bkt_q;
	assign out_position     = out_pos_q;
	assign out_table_empty  = out_empty_q;

	assign sts.op         = op_q;
	assign sts.scan_hit   = scan_hit;
	assign sts.scan_miss  = scan_miss;
	assign sts.shift_done = shift_done;
	assign sts.out_free   = !out_valid_q || out_ready;

endmodule

/* sv/cht_ctrl.sv */
// Controller of the chained hash table: sequences hash, insert, clear, scan,
// shift and response steps of one request. Depends on cht_pkg.
module cht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cht_pkg::cht_sts_t  sts,
	output cht_pkg::cht_cmd_t  cmd
);

	cht_pkg::state_t state_q;
	cht_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			cht_pkg::S_IDLE: begin
				if (in_valid) begin
					state_next = cht_pkg::S_HASH_MUL;
				end
			end
			cht_pkg::S_HASH_MUL: state_next = cht_pkg::S_HASH_MOD;
			cht_pkg::S_HASH_MOD: state_next = cht_pkg::S_EXEC;
			cht_pkg::S_EXEC: begin
				if (sts.op == cht_pkg::OP_SEARCH || sts.op == cht_pkg::OP_DELETE) begin
					state_next = cht_pkg::S_SCAN;
				end else begin
					state_next = cht_pkg::S_DONE;
				end
			end
			cht_pkg::S_SCAN: begin
				if (sts.scan_hit) begin
					state_next = (sts.op == cht_pkg::OP_DELETE) ? cht_pkg::S_SHIFT
						: cht_pkg::S_DONE;
				end else if (sts.scan_miss) begin
					state_next = cht_pkg::S_DONE;
				end
			end
			cht_pkg::S_SHIFT: begin
				if (sts.shift_done) begin
					state_next = cht_pkg::S_DONE;
				end
			end
			cht_pkg::S_DONE: begin
				if (sts.out_free) begin
					state_next = cht_pkg::S_IDLE;
				end
			end
			default: state_next = cht_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			cht_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			cht_pkg::S_HASH_MUL: cmd.hash_mul = 1'b1;
			cht_pkg::S_HASH_MOD: cmd.hash_mod = 1'b1;
			cht_pkg::S_EXEC: begin
				case (sts.op)
					cht_pkg::OP_INSERT: cmd.insert = 1'b1;
					cht_pkg::OP_CLEAR:  cmd.clear = 1'b1;
					default:            cmd.scan_start = 1'b1;
				endcase
			end
			cht_pkg::S_SCAN:  cmd.scan_step = 1'b1;
			cht_pkg::S_SHIFT: cmd.shift_step = 1'b1;
			cht_pkg::S_DONE:  cmd.finish = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* sv/chained_hash_table.sv */
// Chained hash table: a key is a 24.8 fixed-point value whose integer part
// modulo the bucket count selects one of the buckets, each an ordered list of
// up to SLOTS_PER_BUCKET keys held in a single-port-write, single-port-read key
// memory. A request carries an opcode (insert, search, delete, clear) and a
// key, and every request yields exactly one response with status, bucket,
// slot and a table-empty flag. Requests are handled one at a time. With the
// response register free, an insert or clear passes from acceptance through
// the hash multiply, hash modulo, execute and done states to the response.
// A search reads the slots of the bucket in order until it finds the key or
// has read all n filled slots, where n is the fill of the bucket. A delete
// that misses behaves as a search that misses; a delete that hits then
// shifts every later entry of the bucket down by one slot. The scan and the
// shift each move one slot per cycle through the key memory's read port.
// A finished request whose response register is still occupied waits until
// that response is taken. A new request is taken as soon as the previous one
// has been loaded into the response register, even if that response is still
// waiting to be taken. No clearing pass is needed after reset: per-bucket
// fill counts guard every read of the key memory.
// Depends on cht_pkg, cht_req_if, cht_rsp_if, cht_ctrl and cht_dp.
module chained_hash_table (
	input  logic       clk,
	input  logic       arst_n,
	cht_req_if.sink    req,
	cht_rsp_if.source  rsp
);

	cht_pkg::cht_cmd_t cmd;
	cht_pkg::cht_sts_t sts;

	// The controller owns the request handshake and steps the datapath.
	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the table and the response register.
	cht_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_opcode        (req.opcode),
		.in_key           (req.key),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.out_status       (rsp.status),
		.out_bucket_index (rsp.bucket_index),
		.out_position     (rsp.position),
		.out_table_empty  (rsp.table_empty)
	);

endmodule
